[hdl/tbe_pkg.sv]
// Package for the triangular band energy block: band edge tables, the
// descriptor and result word types, and the total rounding and saturation.
// Depends on nothing; every other file but tbe_queue imports it.
`default_nettype none
package tbe_pkg;

	localparam int EDGE_COUNT      = 22;
	localparam int SEG_COUNT       = EDGE_COUNT - 1;
	localparam int NUM_BANDS_DEF   = 22;
	localparam int BIN_SHIFT_DEF   = 2;
	localparam int SAMPLE_BITS_DEF = 18;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF   = 16;

	localparam int BAND_W  = 5;
	localparam int SIZE_W  = 8;
	localparam int FRAC_W  = 16;
	localparam int SUM_W   = 64;
	localparam int TOTAL_W = 45;

	// segment lengths between neighbouring band edges, before scaling
	localparam logic [4:0] SEG_LEN [SEG_COUNT] = '{
		5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
		5'd2, 5'd2, 5'd2, 5'd2, 5'd4, 5'd4, 5'd4, 5'd6,
		5'd6, 5'd8, 5'd12, 5'd18, 5'd22
	};

	// floor(65536 / length) per segment
	localparam logic [16:0] SEG_RECIP [SEG_COUNT] = '{
		17'd65536, 17'd65536, 17'd65536, 17'd65536,
		17'd65536, 17'd65536, 17'd65536, 17'd65536,
		17'd32768, 17'd32768, 17'd32768, 17'd32768,
		17'd16384, 17'd16384, 17'd16384, 17'd10922,
		17'd10922, 17'd8192, 17'd5461, 17'd3640, 17'd2978
	};

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [16:0]       q;
		logic [SIZE_W-1:0] rem;
	} seg_step_t;

	// classification of one bin, handed from the front to the back
	typedef struct packed {
		logic              mode;
		logic              clr;
		logic              last;
		logic              fin;
		logic [BAND_W-1:0] seg;
		logic [FRAC_W-1:0] frac;
	} desc_t;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic [TOTAL_W-1:0] total;
		logic               done;
	} res_t;

	// scaled segment size and the per-bin step of floor(j * 65536 / size)
	function automatic seg_step_t seg_step(logic [BAND_W-1:0] seg, int unsigned shift);
		seg_step_t  s;
		logic [24:0] prod;
		s.size = SIZE_W'({3'b000, SEG_LEN[seg]} << shift);
		s.q    = SEG_RECIP[seg] >> shift;
		prod   = 25'(s.q) * 25'(s.size);
		s.rem  = SIZE_W'(25'h10000 - prod);
		return s;
	endfunction

	// floor of sum / 2^16 (2^15 for a doubled band), clamped to the total range
	function automatic logic [TOTAL_W-1:0] finish_total(logic [SUM_W-1:0] sum, logic dbl);
		logic signed [SUM_W-1:0] sh;
		logic [TOTAL_W-1:0]      r;
		sh = dbl ? ($signed(sum) >>> 15) : ($signed(sum) >>> 16);
		if (sh[SUM_W-1:TOTAL_W-1] == '0 || sh[SUM_W-1:TOTAL_W-1] == '1) begin
			r = sh[TOTAL_W-1:0];
		end else if (sh[SUM_W-1]) begin
			r = {1'b1, {(TOTAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(TOTAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/tbe_front.sv]
// Front end: tracks bin position inside the band segments and classifies
// each accepted bin (segment, weight, segment end, frame end). Uses tbe_pkg.
`default_nettype none
module tbe_front
	import tbe_pkg::*;
#(
	parameter int NUM_BANDS = NUM_BANDS_DEF,
	parameter int BIN_SHIFT = BIN_SHIFT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire logic  mode,
	input  wire logic  frame_start,
	output desc_t      desc
);

	localparam int ACTIVE = (NUM_BANDS < EDGE_COUNT) ? NUM_BANDS : EDGE_COUNT;
	localparam logic [BAND_W-1:0] LAST_SEG = BAND_W'(ACTIVE - 2);

	logic [BAND_W-1:0] seg_q, seg_c;
	logic [SIZE_W-1:0] off_q, off_c, rem_q, rem_c, rem_nx;
	logic [FRAC_W-1:0] frac_q, frac_c;
	seg_step_t         st;
	logic              last, fin, wrap;
	logic [SIZE_W:0]   rem_sum;
	logic [16:0]       frac_sum;

	always_comb begin
		seg_c    = frame_start ? '0 : seg_q;
		off_c    = frame_start ? '0 : off_q;
		rem_c    = frame_start ? '0 : rem_q;
		frac_c   = frame_start ? '0 : frac_q;
		st       = seg_step(seg_c, BIN_SHIFT);
		last     = ({1'b0, off_c} + 9'd1) == {1'b0, st.size};
		fin      = last && (seg_c == LAST_SEG);
		rem_sum  = {1'b0, rem_c} + {1'b0, st.rem};
		wrap     = rem_sum >= {1'b0, st.size};
		rem_nx   = wrap ? SIZE_W'(rem_sum - {1'b0, st.size}) : rem_sum[SIZE_W-1:0];
		frac_sum = 17'(frac_c) + st.q + 17'(wrap);
		desc     = '{mode: mode, clr: frame_start, last: last, fin: fin,
			seg: seg_c, frac: frac_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= '0;
			off_q  <= '0;
			rem_q  <= '0;
			frac_q <= '0;
		end else if (take) begin
			if (last) begin
				// next segment, or back to bin 0 after the last one
				seg_q  <= fin ? '0 : seg_c + BAND_W'(1);
				off_q  <= '0;
				rem_q  <= '0;
				frac_q <= '0;
			end else begin
				seg_q  <= seg_c;
				off_q  <= off_c + SIZE_W'(1);
				rem_q  <= rem_nx;
				frac_q <= frac_sum[FRAC_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[hdl/tbe_queue.sv]
// Short first-in first-out queue of classified bins between front and back.
// Generic width and depth; no package use.
`default_nettype none
module tbe_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

endmodule
`default_nettype wire

[hdl/tbe_back.sv]
// Back end: term multiply, triangular weight split, band accumulation and
// emission of finished bands, with result queue credit. Uses tbe_pkg.
`default_nettype none
module tbe_back
	import tbe_pkg::*;
#(
	parameter int NUM_BANDS   = NUM_BANDS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int RES_DEPTH   = RES_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire desc_t                         q_desc,
	input  wire logic signed [SAMPLE_BITS-1:0] q_a_re,
	input  wire logic signed [SAMPLE_BITS-1:0] q_a_im,
	input  wire logic signed [SAMPLE_BITS-1:0] q_b_re,
	input  wire logic signed [SAMPLE_BITS-1:0] q_b_im,
	output logic                               q_pop,
	input  wire logic                          res_pop,
	output logic [1:0]                         wr_n,
	output res_t                               w0,
	output res_t                               w1
);

	localparam int PW   = 2 * SAMPLE_BITS;
	localparam int TW   = PW + 1;
	localparam int LO_W = TW / 2;
	localparam int HI_W = TW - LO_W;
	localparam int CW   = $clog2(RES_DEPTH + 1);
	localparam logic [BAND_W-1:0] TOP_BAND = BAND_W'(NUM_BANDS - 1);

	logic [CW-1:0]                 used_q;
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, ev_s6;
	desc_t                         d_s1, d_s2, d_s3, d_s4, d_s5;
	logic signed [PW-1:0]          pr_s1, pi_s1;
	logic signed [TW-1:0]          term_s2, term_s3;
	logic [LO_W+FRAC_W-1:0]        lo_s3;
	logic signed [HI_W+FRAC_W:0]   hi_s3;
	logic [SUM_W-1:0]              share_s4, t16_s4, cinc_s5, ninc_s5;
	logic [SUM_W-1:0]              cur_q, next_q, new_cur, new_next;
	logic [SUM_W-1:0]              e0_sum_s6, e1_sum_s6;
	logic [BAND_W-1:0]             e0_band_s6, e1_band_s6;
	logic [1:0]                    en_s6;

	// take a bin only when two result slots are still free
	assign q_pop = q_valid && (used_q <= CW'(RES_DEPTH - 2));

	function automatic logic is_dbl(logic [BAND_W-1:0] band);
		return (band == '0) || (band == TOP_BAND);
	endfunction

	always_ff @(posedge clk) begin
		d_s1  <= q_desc;
		pr_s1 <= q_a_re * (q_desc.mode ? q_b_re : q_a_re);
		pi_s1 <= q_a_im * (q_desc.mode ? q_b_im : q_a_im);

		d_s2    <= d_s1;
		term_s2 <= TW'(pr_s1) + TW'(pi_s1);

		d_s3    <= d_s2;
		term_s3 <= term_s2;
		lo_s3   <= term_s2[LO_W-1:0] * d_s2.frac;
		hi_s3   <= $signed(term_s2[TW-1:LO_W]) * $signed({1'b0, d_s2.frac});

		d_s4     <= d_s3;
		share_s4 <= (SUM_W'(hi_s3) << LO_W) + SUM_W'(lo_s3);
		t16_s4   <= SUM_W'(term_s3) << 16;

		// lower band gets term*65536 minus the upper share
		d_s5    <= d_s4;
		cinc_s5 <= t16_s4 - share_s4;
		ninc_s5 <= share_s4;
	end

	always_comb begin
		new_cur  = (d_s5.clr ? '0 : cur_q) + cinc_s5;
		new_next = (d_s5.clr ? '0 : next_q) + ninc_s5;
	end

	always_ff @(posedge clk) begin
		e0_sum_s6  <= new_cur;
		e1_sum_s6  <= new_next;
		e0_band_s6 <= d_s5.seg;
		e1_band_s6 <= d_s5.seg + BAND_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			ev_s6  <= 1'b0;
			en_s6  <= '0;
			cur_q  <= '0;
			next_q <= '0;
			used_q <= '0;
		end else begin
			v_s1  <= q_pop;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			ev_s6 <= v_s5;
			en_s6 <= '0;
			if (v_s5) begin
				if (!d_s5.last) begin
					cur_q  <= new_cur;
					next_q <= new_next;
				end else if (d_s5.fin) begin
					// close both bands and drop the sums for the next frame
					cur_q  <= '0;
					next_q <= '0;
					en_s6  <= 2'd2;
				end else begin
					cur_q  <= new_next;
					next_q <= '0;
					en_s6  <= 2'd1;
				end
			end
			used_q <= used_q + (q_pop ? CW'(2) : '0)
				- (ev_s6 ? CW'(2) - CW'(en_s6) : '0) - CW'(res_pop);
		end
	end

	always_comb begin
		wr_n = ev_s6 ? en_s6 : '0;
		w0   = '{band: e0_band_s6, total: finish_total(e0_sum_s6, is_dbl(e0_band_s6)),
			done: 1'b0};
		w1   = '{band: e1_band_s6, total: finish_total(e1_sum_s6, is_dbl(e1_band_s6)),
			done: 1'b1};
	end

endmodule
`default_nettype wire

[hdl/tbe_resq.sv]
// Result queue holding finished band words; takes up to two words a cycle.
// Uses tbe_pkg for the result word type.
`default_nettype none
module tbe_resq
	import tbe_pkg::*;
#(
	parameter int DEPTH = RES_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic [1:0] wr_n,
	input  wire res_t  w0,
	input  wire res_t  w1,
	input  wire logic  rd,
	output res_t       rdata,
	output logic       empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wp_q] <= w0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wp_q + PW'(1)] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(wr_n);
			rp_q  <= rp_q + PW'(rd);
			cnt_q <= cnt_q + CW'(wr_n) - CW'(rd);
		end
	end

endmodule
`default_nettype wire

[hdl/triangular_band_energy_top.sv]
// Triangular band energy accumulator, top level.
// Input channel (push/full): one spectrum bin per word, with mode (0 power of
// a, 1 real correlation of a and b), frame_start marking bin 0, and the two
// complex values. A word is taken when push is high and full is low.
// Result channel (empty/pop): one finished band per word: band_number, the
// saturated band_total and frame_done on the last band of the frame. The
// oldest word is shown while empty is low and leaves when pop is high.
// A band word enters the result queue once the bin that closes the band has
// left the back end pipeline; the last bin of a frame closes two bands.
// Throughput: one bin per cycle, set by the six-stage multiply and accumulate
// pipeline in the back end, which takes a bin only when two result slots are
// free in the sixteen-word result queue.
// Reset clears the bin counters, both band sums and all queues; the first
// bin after reset starts a frame whatever frame_start says.
// When the receiver stalls, results collect in the result queue, then the
// back end holds, the four-word bin queue fills and full rises; nothing drops.
// Depends on tbe_pkg, tbe_front, tbe_queue, tbe_back and tbe_resq.
`default_nettype none
module triangular_band_energy_top
	import tbe_pkg::*;
#(
	parameter int NUM_BANDS   = NUM_BANDS_DEF,
	parameter int BIN_SHIFT   = BIN_SHIFT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          mode,
	input  wire logic                          frame_start,
	input  wire logic signed [SAMPLE_BITS-1:0] a_re,
	input  wire logic signed [SAMPLE_BITS-1:0] a_im,
	input  wire logic signed [SAMPLE_BITS-1:0] b_re,
	input  wire logic signed [SAMPLE_BITS-1:0] b_im,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [BAND_W-1:0]                  band_number,
	output logic signed [TOTAL_W-1:0]          band_total,
	output logic                               frame_done
);

	localparam int SW = 4 * SAMPLE_BITS;
	localparam int QW = $bits(desc_t) + SW;

	logic          take, q_valid, q_pop, res_pop;
	desc_t         f_desc, q_desc;
	logic [QW-1:0] q_rdata;
	logic [1:0]    wr_n;
	res_t          w0, w1, head;

	assign take    = push && !full;
	assign res_pop = pop && !empty;

	// classify each bin as it arrives
	tbe_front #(
		.NUM_BANDS (NUM_BANDS),
		.BIN_SHIFT (BIN_SHIFT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.mode        (mode),
		.frame_start (frame_start),
		.desc        (f_desc)
	);

	// hold classified bins with their samples until the back end is free
	tbe_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  ({f_desc, a_re, a_im, b_re, b_im}),
		.full   (full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	assign q_desc = desc_t'(q_rdata[QW-1:SW]);

	// weight, accumulate and close bands
	tbe_back #(
		.NUM_BANDS   (NUM_BANDS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.RES_DEPTH   (RES_DEPTH_DEF)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_desc  (q_desc),
		.q_a_re  ($signed(q_rdata[3*SAMPLE_BITS +: SAMPLE_BITS])),
		.q_a_im  ($signed(q_rdata[2*SAMPLE_BITS +: SAMPLE_BITS])),
		.q_b_re  ($signed(q_rdata[SAMPLE_BITS +: SAMPLE_BITS])),
		.q_b_im  ($signed(q_rdata[0 +: SAMPLE_BITS])),
		.q_pop   (q_pop),
		.res_pop (res_pop),
		.wr_n    (wr_n),
		.w0      (w0),
		.w1      (w1)
	);

	// finished band words wait here for the receiver
	tbe_resq #(
		.DEPTH (RES_DEPTH_DEF)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_n   (wr_n),
		.w0     (w0),
		.w1     (w1),
		.rd     (res_pop),
		.rdata  (head),
		.empty  (empty)
	);

	assign band_number = head.band;
	assign band_total  = $signed(head.total);
	assign frame_done  = head.done;

endmodule
`default_nettype wire
